// ----- rtl/cse_pkg.sv -----
`default_nettype none

package cse_pkg;

  localparam int NUM_SEMS_DEF   = 32;
  localparam int WAIT_DEPTH_DEF = 32;
  localparam int COUNT_BITS_DEF = 8;

  localparam int CMD_W    = 2;
  localparam int SID_W    = 5;
  localparam int PID_W    = 5;
  localparam int INIT_W   = 8;
  localparam int STATUS_W = 3;
  localparam int ACT_W    = 4;

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;
  localparam logic [CMD_W-1:0] CMD_BAD    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SUSPENDED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE_FREE  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_CMD    = 3'd5;

  localparam logic [ACT_W-1:0] ACT_NOP       = 4'd0;
  localparam logic [ACT_W-1:0] ACT_CREATE    = 4'd1;
  localparam logic [ACT_W-1:0] ACT_NONE_FREE = 4'd2;
  localparam logic [ACT_W-1:0] ACT_DEC       = 4'd3;
  localparam logic [ACT_W-1:0] ACT_SUSPEND   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_QFULL     = 4'd5;
  localparam logic [ACT_W-1:0] ACT_INC       = 4'd6;
  localparam logic [ACT_W-1:0] ACT_POP       = 4'd7;
  localparam logic [ACT_W-1:0] ACT_RELEASE   = 4'd8;
  localparam logic [ACT_W-1:0] ACT_BAD       = 4'd9;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [SID_W-1:0]  sem_id;
    logic [PID_W-1:0]  caller_pid;
    logic [INIT_W-1:0] init_count;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SID_W-1:0]    sem_id_out;
    logic [PID_W-1:0]    woken_pid;
  } rsp_t;

  typedef struct packed {
    logic             load;
    logic [ACT_W-1:0] act;
  } ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             in_range;
    logic             pool_empty;
    logic             cnt_pos;
    logic             q_empty;
    logic             q_full;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/counting_semaphore_engine.sv -----
`default_nettype none

// A pool of counting semaphores, each with its own FIFO queue of waiting process ids.
// A request beat (create, lock or unlock) is taken on a rising edge with start high and
// busy low. Its result is shown on rsp for exactly one cycle, marked by done; the
// receiver cannot hold it off and must take it in that cycle.
// Create and lock, like an unlock with no waiter and a bad request, pass through the exec
// state to the result; an unlock that releases a waiter also passes the fetch state, as the
// head of the wait queue is read from the queue memory once the semaphore entry is known.
// Busy is low in the cycle that shows a result, so a new request may be taken at the edge
// that ends it; no new request is taken while one is still in progress.
// Ids are handed out by create in ascending order and are never returned.
// Reset is synchronous and active high. It marks every semaphore entry unset, so it
// reads as a zero count with an empty queue, and it refills the free pool at once;
// no clearing pass is needed. Busy stays high while reset is applied.

module counting_semaphore_engine #(
  parameter int NUM_SEMS   = cse_pkg::NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = cse_pkg::WAIT_DEPTH_DEF,
  parameter int COUNT_BITS = cse_pkg::COUNT_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  cse_pkg::req_t req,
  output logic          done,
  output cse_pkg::rsp_t rsp
);
  import cse_pkg::*;

  ctl_t ctl;
  sts_t sts;

  cse_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  cse_dp #(
    .NUM_SEMS   (NUM_SEMS),
    .WAIT_DEPTH (WAIT_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .ctl (ctl),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/cse_ctrl.sv -----
`default_nettype none

module cse_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  cse_pkg::sts_t      sts,
  output logic               busy,
  output logic               done,
  output cse_pkg::ctl_t      ctl
);
  import cse_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [ACT_W-1:0] exec_act;
  logic             done_next;

  always_comb begin
    priority if (sts.cmd == CMD_CREATE) begin
      exec_act = sts.pool_empty ? ACT_NONE_FREE : ACT_CREATE;
    end else if (sts.cmd == CMD_LOCK && sts.in_range) begin
      if (sts.cnt_pos) begin
        exec_act = ACT_DEC;
      end else if (sts.q_full) begin
        exec_act = ACT_QFULL;
      end else begin
        exec_act = ACT_SUSPEND;
      end
    end else if (sts.cmd == CMD_UNLOCK && sts.in_range) begin
      exec_act = sts.q_empty ? ACT_INC : ACT_POP;
    end else begin
      exec_act = ACT_BAD;
    end
  end

  assign busy = rst || (state != S_IDLE);

  always_comb begin
    ctl.load   = 1'b0;
    ctl.act    = ACT_NOP;
    state_next = state;
    done_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.act = exec_act;
        if (exec_act == ACT_POP) begin
          state_next = S_FETCH;
        end else begin
          state_next = S_IDLE;
          done_next  = 1'b1;
        end
      end
      S_FETCH: begin
        ctl.act    = ACT_RELEASE;
        state_next = S_IDLE;
        done_next  = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cse_dp.sv -----
`default_nettype none

module cse_dp #(
  parameter int NUM_SEMS   = cse_pkg::NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = cse_pkg::WAIT_DEPTH_DEF,
  parameter int COUNT_BITS = cse_pkg::COUNT_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  cse_pkg::req_t req,
  input  cse_pkg::ctl_t ctl,
  output cse_pkg::sts_t sts,
  output cse_pkg::rsp_t rsp
);
  import cse_pkg::*;

  localparam int SIDX_W  = $clog2(NUM_SEMS);
  localparam int ALLOC_W = $clog2(NUM_SEMS + 1);
  localparam int HEAD_W  = $clog2(WAIT_DEPTH);
  localparam int LEN_W   = $clog2(WAIT_DEPTH + 1);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [COUNT_BITS-1:0] count_mem [NUM_SEMS];
  logic [HEAD_W-1:0]     head_mem  [NUM_SEMS];
  logic [LEN_W-1:0]      len_mem   [NUM_SEMS];
  logic [NUM_SEMS-1:0]   ent_ok;
  logic [PID_W-1:0]      wait_mem  [NUM_SEMS][WAIT_DEPTH];

  req_t                  req_q;
  logic [ALLOC_W-1:0]    alloc;
  logic [COUNT_BITS-1:0] rd_count;
  logic [HEAD_W-1:0]     rd_head;
  logic [LEN_W-1:0]      rd_len;
  logic                  rd_ok;
  logic [PID_W-1:0]      rd_pid;

  logic [SIDX_W-1:0]     sidx;
  logic [COUNT_BITS-1:0] e_count;
  logic [HEAD_W-1:0]     e_head;
  logic [LEN_W-1:0]      e_len;
  logic [COUNT_BITS-1:0] init_sat;
  logic [LEN_W:0]        slot_sum;
  logic [HEAD_W-1:0]     slot;
  logic [HEAD_W-1:0]     head_inc;

  logic                  wr_en;
  logic [SIDX_W-1:0]     wr_idx;
  logic [COUNT_BITS-1:0] wr_count;
  logic [HEAD_W-1:0]     wr_head;
  logic [LEN_W-1:0]      wr_len;

  rsp_t                  rsp_next;

  assign sidx    = SIDX_W'(req_q.sem_id);
  assign e_count = rd_ok ? rd_count : '0;
  assign e_head  = rd_ok ? rd_head : '0;
  assign e_len   = rd_ok ? rd_len : '0;

  assign init_sat = (32'(req_q.init_count) > 32'(CNT_MAX)) ? CNT_MAX
                                                           : COUNT_BITS'(req_q.init_count);
  assign slot_sum = (LEN_W + 1)'(e_head) + (LEN_W + 1)'(e_len);
  assign slot     = (slot_sum >= (LEN_W + 1)'(WAIT_DEPTH))
                    ? HEAD_W'(slot_sum - (LEN_W + 1)'(WAIT_DEPTH)) : HEAD_W'(slot_sum);
  assign head_inc = (32'(e_head) == WAIT_DEPTH - 1) ? '0 : e_head + 1'b1;

  assign sts.cmd        = req_q.cmd;
  assign sts.in_range   = 32'(req_q.sem_id) < NUM_SEMS;
  assign sts.pool_empty = (alloc == ALLOC_W'(NUM_SEMS));
  assign sts.cnt_pos    = (e_count != '0);
  assign sts.q_empty    = (e_len == '0);
  assign sts.q_full     = (e_len == LEN_W'(WAIT_DEPTH));

  always_comb begin
    wr_en    = 1'b0;
    wr_idx   = sidx;
    wr_count = e_count;
    wr_head  = e_head;
    wr_len   = e_len;
    unique case (ctl.act)
      ACT_CREATE: begin
        wr_en    = 1'b1;
        wr_idx   = SIDX_W'(alloc);
        wr_count = init_sat;
        wr_head  = '0;
        wr_len   = '0;
      end
      ACT_DEC: begin
        wr_en    = 1'b1;
        wr_count = e_count - 1'b1;
      end
      ACT_SUSPEND: begin
        wr_en  = 1'b1;
        wr_len = e_len + 1'b1;
      end
      ACT_INC: begin
        wr_en = 1'b1;
        if (e_count != CNT_MAX) begin
          wr_count = e_count + 1'b1;
        end
      end
      ACT_POP: begin
        wr_en   = 1'b1;
        wr_head = head_inc;
        wr_len  = e_len - 1'b1;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_q    <= req;
      rd_count <= count_mem[SIDX_W'(req.sem_id)];
      rd_head  <= head_mem[SIDX_W'(req.sem_id)];
      rd_len   <= len_mem[SIDX_W'(req.sem_id)];
    end
    if (wr_en) begin
      count_mem[wr_idx] <= wr_count;
      head_mem[wr_idx]  <= wr_head;
      len_mem[wr_idx]   <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.act == ACT_SUSPEND) begin
      wait_mem[sidx][slot] <= req_q.caller_pid;
    end
    if (ctl.act == ACT_POP) begin
      rd_pid <= wait_mem[sidx][e_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_ok <= '0;
      alloc  <= '0;
      rd_ok  <= 1'b0;
    end else begin
      if (ctl.load) begin
        rd_ok <= ent_ok[SIDX_W'(req.sem_id)];
      end
      if (wr_en) begin
        ent_ok[wr_idx] <= 1'b1;
      end
      if (ctl.act == ACT_CREATE) begin
        alloc <= alloc + 1'b1;
      end
    end
  end

  always_comb begin
    rsp_next = '0;
    unique case (ctl.act)
      ACT_CREATE: begin
        rsp_next.status     = ST_DONE;
        rsp_next.sem_id_out = SID_W'(alloc);
      end
      ACT_NONE_FREE: rsp_next.status = ST_NONE_FREE;
      ACT_DEC:       rsp_next.status = ST_DONE;
      ACT_SUSPEND:   rsp_next.status = ST_SUSPENDED;
      ACT_QFULL:     rsp_next.status = ST_QUEUE_FULL;
      ACT_INC:       rsp_next.status = ST_DONE;
      ACT_RELEASE: begin
        rsp_next.status    = ST_RELEASED;
        rsp_next.woken_pid = rd_pid;
      end
      ACT_BAD:       rsp_next.status = ST_BAD_CMD;
      default:       rsp_next.status = ST_BAD_CMD;
    endcase
  end

  always_ff @(posedge clk) begin
    rsp <= rsp_next;
  end

endmodule

`default_nettype wire

// ----- rtl/cse_checker.sv -----
`default_nettype none

module cse_checker (
  input wire logic     clk,
  input wire logic     rst,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done,
  input cse_pkg::rsp_t rsp
);
  import cse_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while a request is still in progress");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat lasted more than one cycle");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_DONE || rsp.status == ST_SUSPENDED ||
              rsp.status == ST_RELEASED || rsp.status == ST_NONE_FREE ||
              rsp.status == ST_QUEUE_FULL || rsp.status == ST_BAD_CMD))
    else $error("result carries an unknown status");

  a_pid_clear: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_RELEASED |-> rsp.woken_pid == '0)
    else $error("woken pid set without a released waiter");

endmodule

bind counting_semaphore_engine cse_checker u_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .rsp   (rsp)
);

`default_nettype wire
